@@ rtl/core/clt_pkg.sv @@
// Shared types, character codes and result codes for the command-line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

  // Lexer modes
  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_TEXT  = 3'd1;
  localparam logic [2:0] M_QUOTE = 3'd2;
  localparam logic [2:0] M_ESC   = 3'd3;
  localparam logic [2:0] M_CR    = 3'd4;

  // Quote kinds
  localparam logic [1:0] Q_NONE = 2'd0;
  localparam logic [1:0] Q_DQ   = 2'd1;
  localparam logic [1:0] Q_SQ   = 2'd2;
  localparam logic [1:0] Q_BT   = 2'd3;

  // Result kinds
  localparam logic [2:0] K_TBYTE = 3'd0;
  localparam logic [2:0] K_TEND  = 3'd1;
  localparam logic [2:0] K_SING  = 3'd2;
  localparam logic [2:0] K_EOL   = 3'd3;
  localparam logic [2:0] K_EOS   = 3'd4;

  // Line end forms
  localparam logic [1:0] F_LF   = 2'd0;
  localparam logic [1:0] F_CR   = 2'd1;
  localparam logic [1:0] F_CRLF = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_DQ  = 8'h22;
  localparam logic [7:0] CH_SQ  = 8'h27;
  localparam logic [7:0] CH_BS  = 8'h5C;
  localparam logic [7:0] CH_BT  = 8'h60;

  localparam int          SING_COUNT = 17;
  localparam logic [4:0]  NUL_INDEX  = 5'd17;

  localparam logic [7:0] SING_SET [SING_COUNT] = '{
    8'h3D, 8'h5B, 8'h5D, 8'h21, 8'h23, 8'h24, 8'h5E, 8'h26, 8'h2A,
    8'h28, 8'h29, 8'h7C, 8'h3B, 8'h3C, 8'h3E, 8'h3F, 8'h7E
  };

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  chr;
    logic [4:0]  idx;
    logic [1:0]  form;
    logic [31:0] line;
  } res_t;

  // One queue entry holds every result that one input item causes.
  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  // Returns {hit, index}; NUL counts as a singleton with its own index.
  function automatic logic [5:0] sing_lookup(input logic [7:0] b);
    logic [5:0] res;
    res = 6'd0;
    if (b == CH_NUL) begin
      res = {1'b1, NUL_INDEX};
    end
    for (int i = 0; i < SING_COUNT; i++) begin
      if (b == SING_SET[i]) begin
        res = {1'b1, 5'(i)};
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/clt_front.sv @@
// Front end: accepts items, classifies each byte and builds the results it causes.
`timescale 1ns / 1ps

module clt_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  logic [7:0]      in_byte_in,
  input  logic            in_end_of_stream,
  input  logic            cfg_wr_en,
  input  logic [31:0]     cfg_wr_data,
  output clt_pkg::push_t  push
);

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] chr;
    logic [4:0] idx;
    logic [1:0] form;
    logic       use_b;
  } tok_t;

  function automatic tok_t mk(input logic [2:0] kind, input logic [7:0] chr,
                              input logic [4:0] idx, input logic [1:0] form,
                              input logic use_b);
    tok_t t;
    t.kind  = kind;
    t.chr   = chr;
    t.idx   = idx;
    t.form  = form;
    t.use_b = use_b;
    return t;
  endfunction

  logic [2:0]  mode_r, mode_nxt;
  logic [1:0]  quote_r, quote_nxt;
  logic [31:0] lc_r, lc_nxt;
  logic [31:0] start_r;
  logic [31:0] lc_b;

  logic [7:0] b;
  logic [5:0] sl;
  logic       is_sp, is_lf, is_cr, is_dq, is_sq, is_bt, is_bs, qm;

  logic [1:0] tx_cnt, id_cnt, cnt;
  tok_t       tx_a, tx_b, id_a, id_b, ta, tb;
  logic [2:0] tx_mode, id_mode;
  logic [1:0] tx_q, id_q;
  logic       tx_bump, id_bump, bump;
  logic       accept;

  assign b      = in_byte_in;
  assign sl     = clt_pkg::sing_lookup(b);
  assign is_sp  = (b == clt_pkg::CH_SP) || (b == clt_pkg::CH_TAB);
  assign is_lf  = (b == clt_pkg::CH_LF);
  assign is_cr  = (b == clt_pkg::CH_CR);
  assign is_dq  = (b == clt_pkg::CH_DQ);
  assign is_sq  = (b == clt_pkg::CH_SQ);
  assign is_bt  = (b == clt_pkg::CH_BT);
  assign is_bs  = (b == clt_pkg::CH_BS);
  assign qm     = (quote_r == clt_pkg::Q_DQ) ? is_dq :
                  (quote_r == clt_pkg::Q_SQ) ? is_sq : is_bt;
  // The counter stops once it is zero, and wraps to zero from all ones.
  assign lc_b   = (lc_r != 32'd0) ? lc_r + 32'd1 : lc_r;
  assign accept = in_valid && in_ready;

  // Outcome of a byte inside a text token.
  always_comb begin
    tx_cnt  = 2'd1;
    tx_a    = mk(clt_pkg::K_TBYTE, b, 5'd0, 2'd0, 1'b0);
    tx_b    = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
    tx_mode = clt_pkg::M_TEXT;
    tx_q    = quote_r;
    tx_bump = 1'b0;
    if (is_bt) begin
      tx_mode = clt_pkg::M_QUOTE;
      tx_q    = clt_pkg::Q_BT;
    end else if (is_dq) begin
      tx_cnt  = 2'd0;
      tx_mode = clt_pkg::M_QUOTE;
      tx_q    = clt_pkg::Q_DQ;
    end else if (is_sq) begin
      tx_cnt  = 2'd0;
      tx_mode = clt_pkg::M_QUOTE;
      tx_q    = clt_pkg::Q_SQ;
    end else if (is_bs) begin
      tx_cnt  = 2'd0;
      tx_mode = clt_pkg::M_ESC;
    end else if (is_sp) begin
      tx_a    = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
      tx_mode = clt_pkg::M_IDLE;
    end else if (is_cr) begin
      tx_a    = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
      tx_mode = clt_pkg::M_CR;
    end else if (is_lf) begin
      tx_cnt  = 2'd2;
      tx_a    = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
      tx_b    = mk(clt_pkg::K_EOL, 8'd0, 5'd0, clt_pkg::F_LF, 1'b1);
      tx_mode = clt_pkg::M_IDLE;
      tx_bump = 1'b1;
    end else if (sl[5]) begin
      tx_cnt  = 2'd2;
      tx_a    = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
      tx_b    = mk(clt_pkg::K_SING, b, sl[4:0], 2'd0, 1'b0);
      tx_mode = clt_pkg::M_IDLE;
    end
  end

  // Outcome of a byte between tokens.
  always_comb begin
    id_cnt  = tx_cnt;
    id_a    = tx_a;
    id_b    = tx_b;
    id_mode = tx_mode;
    id_q    = tx_q;
    id_bump = tx_bump;
    if (is_sp) begin
      id_cnt  = 2'd0;
      id_mode = clt_pkg::M_IDLE;
    end else if (sl[5]) begin
      id_cnt  = 2'd1;
      id_a    = mk(clt_pkg::K_SING, b, sl[4:0], 2'd0, 1'b0);
      id_mode = clt_pkg::M_IDLE;
    end else if (is_lf) begin
      id_cnt  = 2'd1;
      id_a    = mk(clt_pkg::K_EOL, 8'd0, 5'd0, clt_pkg::F_LF, 1'b1);
      id_mode = clt_pkg::M_IDLE;
      id_bump = 1'b1;
    end else if (is_cr) begin
      id_cnt  = 2'd0;
      id_mode = clt_pkg::M_CR;
    end
  end

  always_comb begin
    cnt       = 2'd0;
    ta        = mk(clt_pkg::K_EOS, 8'd0, 5'd0, 2'd0, 1'b0);
    tb        = mk(clt_pkg::K_EOS, 8'd0, 5'd0, 2'd0, 1'b0);
    mode_nxt  = mode_r;
    quote_nxt = quote_r;
    bump      = 1'b0;
    if (in_end_of_stream) begin
      mode_nxt  = clt_pkg::M_IDLE;
      quote_nxt = clt_pkg::Q_NONE;
      case (mode_r)
        clt_pkg::M_TEXT, clt_pkg::M_QUOTE, clt_pkg::M_ESC: begin
          cnt = 2'd2;
          ta  = mk(clt_pkg::K_TEND, 8'd0, 5'd0, 2'd0, 1'b0);
        end
        clt_pkg::M_CR: begin
          cnt = 2'd2;
          ta  = mk(clt_pkg::K_EOL, 8'd0, 5'd0, clt_pkg::F_CR, 1'b1);
          tb  = mk(clt_pkg::K_EOS, 8'd0, 5'd0, 2'd0, 1'b1);
        end
        default: begin
          cnt = 2'd1;
        end
      endcase
    end else begin
      case (mode_r)
        clt_pkg::M_TEXT: begin
          cnt       = tx_cnt;
          ta        = tx_a;
          tb        = tx_b;
          mode_nxt  = tx_mode;
          quote_nxt = tx_q;
          bump      = tx_bump;
        end
        clt_pkg::M_QUOTE: begin
          if (qm) begin
            cnt       = (quote_r == clt_pkg::Q_BT) ? 2'd1 : 2'd0;
            ta        = mk(clt_pkg::K_TBYTE, b, 5'd0, 2'd0, 1'b0);
            mode_nxt  = clt_pkg::M_TEXT;
            quote_nxt = clt_pkg::Q_NONE;
          end else if (is_cr || is_lf) begin
            // A line end closes the quote and the text token.
            cnt       = tx_cnt;
            ta        = tx_a;
            tb        = tx_b;
            mode_nxt  = tx_mode;
            quote_nxt = clt_pkg::Q_NONE;
            bump      = tx_bump;
          end else begin
            cnt = 2'd1;
            ta  = mk(clt_pkg::K_TBYTE, b, 5'd0, 2'd0, 1'b0);
          end
        end
        clt_pkg::M_ESC: begin
          cnt      = 2'd1;
          ta       = mk(clt_pkg::K_TBYTE, b, 5'd0, 2'd0, 1'b0);
          mode_nxt = clt_pkg::M_TEXT;
        end
        clt_pkg::M_CR: begin
          bump = 1'b1;
          if (is_lf) begin
            cnt      = 2'd1;
            ta       = mk(clt_pkg::K_EOL, 8'd0, 5'd0, clt_pkg::F_CRLF, 1'b1);
            mode_nxt = clt_pkg::M_IDLE;
          end else begin
            // The pending CR ends the line, then the byte is lexed afresh.
            cnt       = 2'd1 + id_cnt;
            ta        = mk(clt_pkg::K_EOL, 8'd0, 5'd0, clt_pkg::F_CR, 1'b1);
            tb        = id_a;
            tb.use_b  = 1'b1;
            mode_nxt  = id_mode;
            quote_nxt = id_q;
          end
        end
        default: begin
          cnt       = id_cnt;
          ta        = id_a;
          tb        = id_b;
          mode_nxt  = id_mode;
          quote_nxt = id_q;
          bump      = id_bump;
        end
      endcase
    end
  end

  always_comb begin
    lc_nxt = lc_r;
    if (cfg_wr_en) begin
      lc_nxt = cfg_wr_data;
    end else if (accept) begin
      if (in_end_of_stream) begin
        lc_nxt = start_r;
      end else if (bump) begin
        lc_nxt = lc_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= clt_pkg::M_IDLE;
      quote_r <= clt_pkg::Q_NONE;
      lc_r    <= 32'd0;
      start_r <= 32'd0;
    end else begin
      lc_r <= lc_nxt;
      if (cfg_wr_en) begin
        start_r <= cfg_wr_data;
      end
      if (accept) begin
        mode_r  <= mode_nxt;
        quote_r <= quote_nxt;
      end
    end
  end

  always_comb begin
    push.valid          = in_valid && (cnt != 2'd0);
    push.entry.two      = (cnt == 2'd2);
    push.entry.r0.kind  = ta.kind;
    push.entry.r0.chr   = ta.chr;
    push.entry.r0.idx   = ta.idx;
    push.entry.r0.form  = ta.form;
    push.entry.r0.line  = ta.use_b ? lc_b : lc_r;
    push.entry.r1.kind  = tb.kind;
    push.entry.r1.chr   = tb.chr;
    push.entry.r1.idx   = tb.idx;
    push.entry.r1.form  = tb.form;
    push.entry.r1.line  = tb.use_b ? lc_b : lc_r;
  end

endmodule

@@ rtl/core/clt_queue.sv @@
// Short queue of result entries between the front end and the back end.
`timescale 1ns / 1ps

module clt_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  clt_pkg::push_t   push,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output clt_pkg::entry_t  head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clt_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign nonempty = (count_r != '0);
  assign do_push  = push.valid && !full;
  assign do_pop   = pop && nonempty;
  assign head     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/clt_back.sv @@
// Back end: output register that hands out the results of each entry in order.
`timescale 1ns / 1ps

module clt_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_nonempty,
  input  clt_pkg::entry_t  q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_token_kind,
  output logic [7:0]       out_byte_out,
  output logic [4:0]       out_singleton_index,
  output logic [1:0]       out_eol_form,
  output logic [31:0]      out_line_number,
  output logic             out_last
);

  clt_pkg::entry_t buf_r;
  clt_pkg::res_t   cur;
  logic            valid_r;
  logic            phase_r;
  logic            final_res;

  assign final_res = !buf_r.two || phase_r;
  assign q_pop     = q_nonempty && (!valid_r || (out_ready && final_res));
  assign cur       = phase_r ? buf_r.r1 : buf_r.r0;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      buf_r <= q_head;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      phase_r <= 1'b0;
    end else if (valid_r && out_ready) begin
      if (final_res) begin
        valid_r <= 1'b0;
        phase_r <= 1'b0;
      end else begin
        phase_r <= 1'b1;
      end
    end
  end

  assign out_valid           = valid_r;
  assign out_token_kind      = cur.kind;
  assign out_byte_out        = cur.chr;
  assign out_singleton_index = cur.idx;
  assign out_eol_form        = cur.form;
  assign out_line_number     = cur.line;
  assign out_last            = final_res;

endmodule

@@ rtl/core/command_line_tokenizer_unit.sv @@
// Top level of the command-line tokenizer: front end, result queue and back end.
//
// Input channel (in_valid/in_ready): one byte per item, or an end-of-stream
// mark. Output channel (out_valid/out_ready): one token result per transfer,
// with out_last set on the final result that an item causes. An item causes
// zero, one or two results. cfg_wr_en/cfg_wr_data load the starting line
// number and the line counter at once; write only while the block is idle.
// An item's entry goes into the queue at its accepting edge and moves on into the
// back end's output register once that is free. The front end takes one item every
// cycle while the queue has room, so the rate is one item per cycle whenever each
// item yields at most one result and out_ready stays high; the back end issues one
// result per cycle while out_ready is high. Items with no result never enter the queue.
// If the receiver stalls, the back end holds its result and the queue fills;
// in_ready falls once the QUEUE_DEPTH entries are all taken.
// Reset clears the lexer state, the counter, the starting line and the
// queue; the block is ready in the cycle after reset is released.
`timescale 1ns / 1ps

module command_line_tokenizer_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_token_kind,
  output logic [7:0]  out_byte_out,
  output logic [4:0]  out_singleton_index,
  output logic [1:0]  out_eol_form,
  output logic [31:0] out_line_number,
  output logic        out_last,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  clt_pkg::push_t  push;
  clt_pkg::entry_t q_head;
  logic            q_full, q_nonempty, q_pop;

  assign in_ready = !q_full;

  clt_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_in       (in_byte_in),
    .in_end_of_stream (in_end_of_stream),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .push             (push)
  );

  clt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  clt_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_nonempty          (q_nonempty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_byte_out        (out_byte_out),
    .out_singleton_index (out_singleton_index),
    .out_eol_form        (out_eol_form),
    .out_line_number     (out_line_number),
    .out_last            (out_last)
  );

endmodule

@@ tb/command_line_tokenizer_unit_tb.sv @@
// Self-checking testbench for the command-line tokenizer: directed table, random streams.
`timescale 1ns / 1ps

module command_line_tokenizer_unit_tb;

  localparam logic [7:0] NO_CHAR = 8'd0;
  localparam logic [4:0] NO_INDEX = 5'd0;
  localparam logic [1:0] NO_FORM = 2'd0;
  localparam string SING_CHARS = "=[]!#$^&*()|;<>?~";
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  chr;
    logic [4:0]  idx;
    logic [1:0]  form;
    logic [31:0] line;
    logic        last;
  } token_t;

  // One input item; typed rows also carry the single result they must give.
  typedef struct packed {
    logic [7:0] chr;
    logic       eos;
    logic       typed;
    logic [2:0] kind;
    logic [4:0] idx;
    logic [1:0] form;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'd0;
  logic        in_end_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_token_kind;
  logic [7:0]  out_byte_out;
  logic [4:0]  out_singleton_index;
  logic [1:0]  out_eol_form;
  logic [31:0] out_line_number;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = 32'd0;

  command_line_tokenizer_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_byte_in          (in_byte_in),
    .in_end_of_stream    (in_end_of_stream),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_token_kind      (out_token_kind),
    .out_byte_out        (out_byte_out),
    .out_singleton_index (out_singleton_index),
    .out_eol_form        (out_eol_form),
    .out_line_number     (out_line_number),
    .out_last            (out_last),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Lexer state as the block should hold it.
  logic [2:0]  lex_mode = clt_pkg::M_IDLE;
  logic [1:0]  quote_sel = clt_pkg::Q_NONE;
  logic [31:0] line_ctr = 32'd0;
  logic [31:0] first_line = 32'd0;
  token_t      step_toks[$];
  token_t      want_toks[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int tokens_seen = 0;
  int directed_count = 0;
  logic [31:0] last_start = 32'd0;

  row_t plan [26] = '{
    '{8'h3D, 1'b0, 1'b1, clt_pkg::K_SING, 5'd0, NO_FORM},      // '=' heads the set
    '{8'h7E, 1'b0, 1'b1, clt_pkg::K_SING, 5'd16, NO_FORM},     // '~' ends it
    '{clt_pkg::CH_NUL, 1'b0, 1'b1, clt_pkg::K_SING, clt_pkg::NUL_INDEX, NO_FORM},
    '{clt_pkg::CH_LF, 1'b0, 1'b1, clt_pkg::K_EOL, NO_INDEX, clt_pkg::F_LF},
    '{8'hA5, 1'b1, 1'b1, clt_pkg::K_EOS, NO_INDEX, NO_FORM},   // byte ignored at stream end
    '{8'h61, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{8'hFF, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_BS, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_NUL, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM}, // escaped NUL is text
    '{clt_pkg::CH_DQ, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_SP, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_DQ, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_SQ, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_CR, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},  // line end closes quote
    '{clt_pkg::CH_LF, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_SQ, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},  // empty quoted text
    '{clt_pkg::CH_SQ, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_TAB, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_BT, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_LF, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_CR, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{8'h28, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},   // lone CR, then '('
    '{8'h7A, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{8'h7C, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{clt_pkg::CH_CR, 1'b0, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM},
    '{8'h5A, 1'b1, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM}    // stream ends while a CR waits
  };

  function automatic void emit(input logic [2:0] kind, input logic [7:0] chr,
                               input logic [4:0] idx, input logic [1:0] form);
    token_t t;
    t.kind = kind;
    t.chr = chr;
    t.idx = idx;
    t.form = form;
    t.line = line_ctr;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void count_line();
    if (line_ctr != 32'd0) begin
      line_ctr = line_ctr + 32'd1;
    end
  endfunction

  function automatic int sing_pos(input logic [7:0] b);
    if (b == clt_pkg::CH_NUL) begin
      return clt_pkg::NUL_INDEX;
    end
    for (int i = 0; i < SING_CHARS.len(); i++) begin
      if (SING_CHARS[i] == b) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic void lex_text(input logic [7:0] b);
    int s;
    case (b)
      clt_pkg::CH_BT: begin
        emit(clt_pkg::K_TBYTE, b, NO_INDEX, NO_FORM);
        lex_mode = clt_pkg::M_QUOTE;
        quote_sel = clt_pkg::Q_BT;
      end
      clt_pkg::CH_DQ: begin
        lex_mode = clt_pkg::M_QUOTE;
        quote_sel = clt_pkg::Q_DQ;
      end
      clt_pkg::CH_SQ: begin
        lex_mode = clt_pkg::M_QUOTE;
        quote_sel = clt_pkg::Q_SQ;
      end
      clt_pkg::CH_BS: lex_mode = clt_pkg::M_ESC;
      clt_pkg::CH_SP, clt_pkg::CH_TAB: begin
        lex_mode = clt_pkg::M_IDLE;
        emit(clt_pkg::K_TEND, NO_CHAR, NO_INDEX, NO_FORM);
      end
      clt_pkg::CH_CR: begin
        lex_mode = clt_pkg::M_CR;
        emit(clt_pkg::K_TEND, NO_CHAR, NO_INDEX, NO_FORM);
      end
      clt_pkg::CH_LF: begin
        lex_mode = clt_pkg::M_IDLE;
        emit(clt_pkg::K_TEND, NO_CHAR, NO_INDEX, NO_FORM);
        count_line();
        emit(clt_pkg::K_EOL, NO_CHAR, NO_INDEX, clt_pkg::F_LF);
      end
      default: begin
        s = sing_pos(b);
        if (s >= 0) begin
          lex_mode = clt_pkg::M_IDLE;
          emit(clt_pkg::K_TEND, NO_CHAR, NO_INDEX, NO_FORM);
          emit(clt_pkg::K_SING, b, 5'(s), NO_FORM);
        end else begin
          emit(clt_pkg::K_TBYTE, b, NO_INDEX, NO_FORM);
        end
      end
    endcase
  endfunction

  function automatic void lex_idle(input logic [7:0] b);
    int s;
    if (b == clt_pkg::CH_SP || b == clt_pkg::CH_TAB) begin
      return;
    end
    s = sing_pos(b);
    if (s >= 0) begin
      emit(clt_pkg::K_SING, b, 5'(s), NO_FORM);
    end else if (b == clt_pkg::CH_LF) begin
      count_line();
      emit(clt_pkg::K_EOL, NO_CHAR, NO_INDEX, clt_pkg::F_LF);
    end else if (b == clt_pkg::CH_CR) begin
      lex_mode = clt_pkg::M_CR;
    end else begin
      lex_mode = clt_pkg::M_TEXT;
      lex_text(b);
    end
  endfunction

  function automatic void lex_quote(input logic [7:0] b);
    logic [7:0] closer;
    closer = (quote_sel == clt_pkg::Q_DQ) ? clt_pkg::CH_DQ :
             (quote_sel == clt_pkg::Q_SQ) ? clt_pkg::CH_SQ : clt_pkg::CH_BT;
    if (b == closer) begin
      // Backticks stay in the text; the other quotes vanish.
      if (quote_sel == clt_pkg::Q_BT) begin
        emit(clt_pkg::K_TBYTE, b, NO_INDEX, NO_FORM);
      end
      lex_mode = clt_pkg::M_TEXT;
      quote_sel = clt_pkg::Q_NONE;
    end else if (b == clt_pkg::CH_CR || b == clt_pkg::CH_LF) begin
      lex_mode = clt_pkg::M_TEXT;
      quote_sel = clt_pkg::Q_NONE;
      lex_text(b);
    end else begin
      emit(clt_pkg::K_TBYTE, b, NO_INDEX, NO_FORM);
    end
  endfunction

  // Fills step_toks with the results of one accepted item.
  function automatic void lex_item(input logic [7:0] b, input logic eos);
    step_toks.delete();
    if (eos) begin
      case (lex_mode)
        clt_pkg::M_TEXT, clt_pkg::M_QUOTE, clt_pkg::M_ESC:
          emit(clt_pkg::K_TEND, NO_CHAR, NO_INDEX, NO_FORM);
        clt_pkg::M_CR: begin
          count_line();
          emit(clt_pkg::K_EOL, NO_CHAR, NO_INDEX, clt_pkg::F_CR);
        end
        default: ;
      endcase
      emit(clt_pkg::K_EOS, NO_CHAR, NO_INDEX, NO_FORM);
      lex_mode = clt_pkg::M_IDLE;
      quote_sel = clt_pkg::Q_NONE;
      line_ctr = first_line;
    end else begin
      case (lex_mode)
        clt_pkg::M_TEXT: lex_text(b);
        clt_pkg::M_QUOTE: lex_quote(b);
        clt_pkg::M_ESC: begin
          lex_mode = clt_pkg::M_TEXT;
          emit(clt_pkg::K_TBYTE, b, NO_INDEX, NO_FORM);
        end
        clt_pkg::M_CR: begin
          // The byte after a CR settles its form; anything but LF is lexed afresh.
          lex_mode = clt_pkg::M_IDLE;
          count_line();
          if (b == clt_pkg::CH_LF) begin
            emit(clt_pkg::K_EOL, NO_CHAR, NO_INDEX, clt_pkg::F_CRLF);
          end else begin
            emit(clt_pkg::K_EOL, NO_CHAR, NO_INDEX, clt_pkg::F_CR);
            lex_idle(b);
          end
        end
        default: begin
          lex_mode = clt_pkg::M_IDLE;
          lex_idle(b);
        end
      endcase
    end
    if (step_toks.size() > 0) begin
      step_toks[step_toks.size() - 1].last = 1'b1;
    end
  endfunction

  function automatic row_t plain_row(input logic [7:0] b, input logic eos);
    row_t r;
    r = '{b, eos, 1'b0, clt_pkg::K_TBYTE, NO_INDEX, NO_FORM};
    return r;
  endfunction

  // Offers one item, holding it until accepted, then records what it should yield.
  task automatic send_item(input row_t r);
    token_t t;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte_in <= r.chr;
    in_end_of_stream <= r.eos;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    lex_item(r.chr, r.eos);
    if (r.typed) begin
      // Counting is off in the directed part, so every line number is zero.
      t.kind = r.kind;
      t.chr = (r.kind == clt_pkg::K_SING) ? r.chr : NO_CHAR;
      t.idx = r.idx;
      t.form = r.form;
      t.line = 32'd0;
      t.last = 1'b1;
      want_toks.push_back(t);
    end else begin
      foreach (step_toks[i]) begin
        want_toks.push_back(step_toks[i]);
      end
    end
  endtask

  task automatic load_start_line(input logic [31:0] value);
    in_valid <= 1'b0;
    while (want_toks.size() != 0) begin
      @(posedge clk);
    end
    // An item with no result may still be in flight.
    repeat (4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    first_line = value;
    line_ctr = value;
    last_start = value;
  endtask

  // Mostly well-formed command lines with random content, some raw noise.
  task automatic offer_stream(input int count);
    row_t piece[$];
    int pick;
    int len;
    int done;
    int k;
    logic [7:0] opener;
    done = 0;
    while (done < count) begin
      piece.delete();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        len = $urandom_range(1, 6);
        repeat (len) piece.push_back(plain_row(8'($urandom_range(8'h61, 8'h7A)), 1'b0));
      end else if (pick < 42) begin
        k = $urandom_range(0, 2);
        opener = (k == 0) ? clt_pkg::CH_DQ : (k == 1) ? clt_pkg::CH_SQ : clt_pkg::CH_BT;
        piece.push_back(plain_row(opener, 1'b0));
        len = $urandom_range(0, 5);
        repeat (len) begin
          if ($urandom_range(0, 9) == 0) begin
            piece.push_back(plain_row(8'($urandom_range(0, 255)), 1'b0));
          end else begin
            piece.push_back(plain_row(8'($urandom_range(8'h20, 8'h7E)), 1'b0));
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          piece.push_back(plain_row(opener, 1'b0));
        end
      end else if (pick < 52) begin
        k = $urandom_range(0, 17);
        piece.push_back(plain_row((k == 17) ? clt_pkg::CH_NUL : 8'(SING_CHARS[k]), 1'b0));
      end else if (pick < 65) begin
        len = $urandom_range(1, 3);
        repeat (len) begin
          piece.push_back(plain_row($urandom_range(0, 1) ? clt_pkg::CH_SP : clt_pkg::CH_TAB,
                                    1'b0));
        end
      end else if (pick < 72) begin
        piece.push_back(plain_row(clt_pkg::CH_BS, 1'b0));
        if ($urandom_range(0, 4) != 0) begin
          piece.push_back(plain_row(8'($urandom_range(0, 255)), 1'b0));
        end
      end else if (pick < 85) begin
        k = $urandom_range(0, 2);
        if (k != 0) begin
          piece.push_back(plain_row(clt_pkg::CH_CR, 1'b0));
        end
        if (k != 1) begin
          piece.push_back(plain_row(clt_pkg::CH_LF, 1'b0));
        end
      end else if (pick < 88) begin
        piece.push_back(plain_row(8'($urandom_range(0, 255)), 1'b1));
      end else begin
        piece.push_back(plain_row(8'($urandom_range(0, 255)), 1'b0));
      end
      foreach (piece[i]) begin
        send_item(piece[i]);
      end
      done += piece.size();
    end
  endtask

  // The receiver stalls at random, and once holds off for a long stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    token_t exp_tok;
    if (rst_n && out_valid && out_ready) begin
      tokens_seen++;
      if (want_toks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d byte %0h",
                 $time, out_token_kind, out_byte_out);
        mismatches++;
      end else begin
        exp_tok = want_toks.pop_front();
        check_field("token_kind", 32'(exp_tok.kind), 32'(out_token_kind));
        check_field("byte_out", 32'(exp_tok.chr), 32'(out_byte_out));
        check_field("singleton_index", 32'(exp_tok.idx), 32'(out_singleton_index));
        check_field("eol_form", 32'(exp_tok.form), 32'(out_eol_form));
        check_field("line_number", exp_tok.line, out_line_number);
        check_field("last", 32'(exp_tok.last), 32'(out_last));
      end
    end
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = 19;
    rx_idle_pct = 84;
    load_start_line(32'd0);
    foreach (plan[i]) begin
      send_item(plan[i]);
    end
    directed_count = items_sent;
    load_start_line(32'd1);
    offer_stream(260);
    tx_idle_pct = 84;
    rx_idle_pct = 19;
    load_start_line(32'hFFFF_FFFF);
    offer_stream(260);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    load_start_line($urandom());
    hold_req = 1'b1;
    offer_stream(260);
    in_valid <= 1'b0;
    while (want_toks.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    $display("Checked %0d results from %0d items, %0d of them from the directed table.",
             tokens_seen, items_sent, directed_count);
    $display("Start lines 0, 1, all ones and %0h; stalls on each side, then a long hold.",
             last_start);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
